>>> hdl/fcl_pkg.sv
package fcl_pkg;

  localparam int MAX_NODES  = 64;
  localparam int MAX_INPUTS = 1024;

  localparam int NODE_W  = 6;
  localparam int ELEM_W  = 10;
  localparam int WADDR_W = NODE_W + ELEM_W;
  localparam int NI_W    = 11;
  localparam int NN_W    = 7;
  localparam int VAL_W   = 16;
  localparam int PROD_W  = 32;
  localparam int ACC_W   = 40;
  localparam int RES_W   = 32;

  localparam logic [NI_W-1:0] INPUTS_RESET = NI_W'(784);
  localparam logic [NN_W-1:0] NODES_RESET  = NN_W'(64);

  typedef enum logic [1:0] {
    CMD_WEIGHT,
    CMD_BIAS,
    CMD_FEED,
    CMD_READ
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_RANGE,
    ST_INCOMPLETE
  } status_t;

  typedef enum logic [1:0] {
    CFG_INPUTS,
    CFG_NODES,
    CFG_MODE
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FEED,
    S_DRAIN,
    S_RD,
    S_EMIT
  } state_t;

  typedef struct packed {
    cmd_t                    command;
    logic [NODE_W-1:0]       node_index;
    logic [ELEM_W-1:0]       elem_index;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [RES_W-1:0] result_value;
    status_t                 status;
  } out_item_t;

  typedef struct packed {
    logic                    vld;
    logic [NODE_W-1:0]       idx;
    logic signed [VAL_W-1:0] weight;
    logic signed [VAL_W-1:0] elem;
    logic signed [ACC_W-1:0] acc;
  } mac_in_t;

  typedef struct packed {
    logic                    vld;
    logic [NODE_W-1:0]       idx;
    logic signed [ACC_W-1:0] acc;
  } mac_out_t;

endpackage

>>> hdl/fcl_mac.sv
module fcl_mac import fcl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mac_in_t  mac_in,
  output mac_out_t mac_out
);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic                     vld_r;
  logic [NODE_W-1:0]        idx_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W:0]    sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= mac_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= mac_in.idx;
    prod_r <= mac_in.weight * mac_in.elem;
    acc_r  <= mac_in.acc;
  end

  // saturating 40-bit accumulate
  always_comb begin
    sum = {acc_r[ACC_W-1], acc_r} + {{(ACC_W+1-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    mac_out.vld = vld_r;
    mac_out.idx = idx_r;
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      mac_out.acc = sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      mac_out.acc = sum[ACC_W-1:0];
    end
  end

endmodule

>>> hdl/fully_connected_layer_core.sv
// Each accepted item goes through S_EMIT into the output register: a weight or bias
// write or a failed command directly, a read via S_RD, a feed via S_FEED and S_DRAIN.
// One item at a time; in_ready is high only in S_IDLE, and the next item waits while
// the previous result waits for out_ready.
// rst_n is synchronous; node sums read as zero after reset via per-node valid flags.
// Weight and bias memories are not cleared by reset.
module fully_connected_layer_core import fcl_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_item_t        in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output out_item_t       out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [NI_W-1:0] cfg_data
);

  localparam logic signed [ACC_W:0] RES_MAX = (ACC_W+1)'(64'sd2147483647);
  localparam logic signed [ACC_W:0] RES_MIN = (ACC_W+1)'(-64'sd2147483648);

  state_t state_r, state_nxt;

  logic [NI_W-1:0]   active_inputs_r;
  logic [NN_W-1:0]   active_nodes_r;
  logic              act_mode_r;
  logic [NI_W-1:0]   ni_eff;
  logic [NN_W-1:0]   nn_eff;
  logic [NI_W-1:0]   fed_r, fed_nxt;
  logic [NODE_W-1:0] k_r, k_nxt;
  logic [ELEM_W-1:0] elem_r;
  logic signed [VAL_W-1:0] val_r;
  out_item_t         res_r, res_nxt;
  logic              out_valid_r;
  out_item_t         out_data_r;
  logic              accept, node_bad, elem_bad;
  logic              w_we, b_we, issue, clr_valid, load_feed, out_load;
  logic [WADDR_W-1:0] w_addr;
  logic [NODE_W-1:0] s_addr;

  logic signed [VAL_W-1:0] weight_mem [MAX_NODES*MAX_INPUTS];
  logic signed [VAL_W-1:0] bias_mem   [MAX_NODES];
  logic signed [ACC_W-1:0] sum_mem    [MAX_NODES];
  logic [MAX_NODES-1:0]    sum_valid_r;

  logic signed [VAL_W-1:0] w_rd_r, b_rd_r;
  logic signed [ACC_W-1:0] s_rd_r, acc_rd;
  logic                    sv_r;
  logic                    p1_vld_r;
  logic [NODE_W-1:0]       p1_idx_r;
  logic signed [ACC_W:0]   rd_sum;
  logic signed [RES_W-1:0] rd_value;

  mac_in_t  mac_in;
  mac_out_t mac_out;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ni_eff = (active_inputs_r == '0) ? NI_W'(1) :
                  (active_inputs_r > NI_W'(MAX_INPUTS)) ? NI_W'(MAX_INPUTS) : active_inputs_r;
  assign nn_eff = (active_nodes_r == '0) ? NN_W'(1) :
                  (active_nodes_r > NN_W'(MAX_NODES)) ? NN_W'(MAX_NODES) : active_nodes_r;

  assign node_bad = {1'b0, in_data.node_index} >= nn_eff;
  assign elem_bad = {1'b0, in_data.elem_index} >= ni_eff;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_inputs_r <= INPUTS_RESET;
      active_nodes_r  <= NODES_RESET;
      act_mode_r      <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_INPUTS: active_inputs_r <= cfg_data;
        CFG_NODES:  active_nodes_r  <= cfg_data[NN_W-1:0];
        CFG_MODE:   act_mode_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fed_r   <= '0;
    end else begin
      state_r <= state_nxt;
      fed_r   <= fed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    res_r <= res_nxt;
    if (load_feed) begin
      elem_r <= in_data.elem_index;
      val_r  <= in_data.value;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    res_nxt   = res_r;
    fed_nxt   = fed_r;
    w_we      = 1'b0;
    b_we      = 1'b0;
    issue     = 1'b0;
    clr_valid = 1'b0;
    load_feed = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt.result_value = '0;
          res_nxt.status       = ST_OK;
          state_nxt            = S_EMIT;
          unique case (in_data.command)
            CMD_WEIGHT: begin
              if (node_bad || elem_bad) res_nxt.status = ST_RANGE;
              else w_we = 1'b1;
            end
            CMD_BIAS: begin
              if (node_bad) res_nxt.status = ST_RANGE;
              else b_we = 1'b1;
            end
            CMD_FEED: begin
              if (elem_bad) begin
                res_nxt.status = ST_RANGE;
              end else begin
                load_feed = 1'b1;
                clr_valid = (in_data.elem_index == '0);
                fed_nxt   = {1'b0, in_data.elem_index} + NI_W'(1);
                k_nxt     = '0;
                state_nxt = S_FEED;
              end
            end
            CMD_READ: begin
              if (node_bad) res_nxt.status = ST_RANGE;
              else if (fed_r < ni_eff) res_nxt.status = ST_INCOMPLETE;
              else state_nxt = S_RD;
            end
          endcase
        end
      end
      S_FEED: begin
        issue = 1'b1;
        if ({1'b0, k_r} == nn_eff - NN_W'(1)) state_nxt = S_DRAIN;
        else k_nxt = k_r + NODE_W'(1);
      end
      S_DRAIN: begin
        if (!p1_vld_r && !mac_out.vld) state_nxt = S_EMIT;
      end
      S_RD: begin
        res_nxt.result_value = rd_value;
        state_nxt            = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register
  assign out_load = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data_r <= res_r;
  end

  // memories
  assign w_addr = (state_r == S_FEED) ? {k_r, elem_r} :
                                        {in_data.node_index, in_data.elem_index};
  assign s_addr = (state_r == S_FEED) ? k_r : in_data.node_index;

  always_ff @(posedge clk) begin
    if (w_we) weight_mem[w_addr] <= in_data.value;
    w_rd_r <= weight_mem[w_addr];
  end

  always_ff @(posedge clk) begin
    if (b_we) bias_mem[in_data.node_index] <= in_data.value;
    b_rd_r <= bias_mem[in_data.node_index];
  end

  always_ff @(posedge clk) begin
    if (mac_out.vld) sum_mem[mac_out.idx] <= mac_out.acc;
    s_rd_r <= sum_mem[s_addr];
    sv_r   <= sum_valid_r[s_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_valid_r <= '0;
    end else if (clr_valid) begin
      sum_valid_r <= '0;
    end else if (mac_out.vld) begin
      sum_valid_r[mac_out.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    p1_idx_r <= k_r;
  end

  assign acc_rd = sv_r ? s_rd_r : '0;

  always_comb begin
    mac_in.vld    = p1_vld_r;
    mac_in.idx    = p1_idx_r;
    mac_in.weight = w_rd_r;
    mac_in.elem   = val_r;
    mac_in.acc    = acc_rd;
  end

  fcl_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .mac_in  (mac_in),
    .mac_out (mac_out)
  );

  // read: sum plus bias in Q16.16, saturate, optional ReLU
  always_comb begin
    rd_sum = {acc_rd[ACC_W-1], acc_rd} +
             {{(ACC_W+1-VAL_W-8){b_rd_r[VAL_W-1]}}, b_rd_r, 8'b0};
    if (rd_sum > RES_MAX) rd_value = RES_MAX[RES_W-1:0];
    else if (rd_sum < RES_MIN) rd_value = RES_MIN[RES_W-1:0];
    else rd_value = rd_sum[RES_W-1:0];
    if (act_mode_r && rd_value[RES_W-1]) rd_value = '0;
  end

  a_no_wwrite_in_feed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FEED || state_r == S_DRAIN) |-> !w_we && !b_we)
    else $error("store write during feed pass");

  a_mac_only_in_feed: assert property (@(posedge clk) disable iff (!rst_n)
    mac_out.vld |-> (state_r == S_DRAIN || state_r == S_FEED))
    else $error("accumulator write outside feed pass");

  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN && state_nxt == S_EMIT) |=> !mac_out.vld && !p1_vld_r)
    else $error("result issued with accumulations in flight");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status != ST_OK) |-> out_data_r.result_value == '0)
    else $error("failed item carries a value");

  a_ready_clear_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && !in_ready == 1'b0)
    else $error("block not idle after result load");

endmodule

>>> tb/fully_connected_layer_core_tb.sv
`timescale 1ns / 1ps

module fully_connected_layer_core_tb;
  import fcl_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam longint ACC_HI = 64'sd549755813887;
  localparam longint ACC_LO = -64'sd549755813888;
  localparam longint OUT_HI = 64'sd2147483647;
  localparam longint OUT_LO = -64'sd2147483648;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  in_item_t        in_data;
  logic            out_valid;
  logic            out_ready;
  out_item_t       out_data;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [1:0]      cfg_index;
  logic [NI_W-1:0] cfg_data;

  // predictor state
  logic signed [VAL_W-1:0] weight_mem [MAX_NODES*MAX_INPUTS];
  bit                      weight_set [MAX_NODES*MAX_INPUTS];
  logic signed [VAL_W-1:0] bias_mem [MAX_NODES];
  bit                      bias_set [MAX_NODES];
  longint                  node_acc [MAX_NODES];
  int                      vec_fill;
  logic [NI_W-1:0]         inputs_reg;
  logic [NN_W-1:0]         nodes_reg;
  logic                    relu_on;

  out_item_t results_due [$];
  out_item_t due_item;
  int        mismatches;
  int        items_used;
  int        quiet_cycles;
  int        send_gap_pct;
  int        stall_pct;

  fully_connected_layer_core dut (.*);

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic int used_inputs();
    int n;
    n = inputs_reg;
    if (n < 1) n = 1;
    if (n > MAX_INPUTS) n = MAX_INPUTS;
    return n;
  endfunction

  function automatic int used_nodes();
    int n;
    n = nodes_reg;
    if (n < 1) n = 1;
    if (n > MAX_NODES) n = MAX_NODES;
    return n;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int rand_value();
    case ($urandom_range(7))
      0: return -32768;
      1: return 32767;
      default: return $urandom_range(65535);
    endcase
  endfunction

  function automatic out_item_t layer_predict(in_item_t it);
    out_item_t r;
    int ni, nn, k;
    longint acc;
    logic [WADDR_W-1:0] a;
    ni = used_inputs();
    nn = used_nodes();
    r.result_value = '0;
    r.status = ST_OK;
    case (it.command)
      CMD_WEIGHT: begin
        if (it.node_index >= nn || it.elem_index >= ni) begin
          r.status = ST_RANGE;
        end else begin
          a = {it.node_index, it.elem_index};
          weight_mem[a] = it.value;
          weight_set[a] = 1'b1;
        end
      end
      CMD_BIAS: begin
        if (it.node_index >= nn) begin
          r.status = ST_RANGE;
        end else begin
          bias_mem[it.node_index] = it.value;
          bias_set[it.node_index] = 1'b1;
        end
      end
      CMD_FEED: begin
        if (it.elem_index >= ni) begin
          r.status = ST_RANGE;
        end else begin
          if (it.elem_index == 0) begin
            for (k = 0; k < MAX_NODES; k++) node_acc[k] = 0;
          end
          for (k = 0; k < nn; k++) begin
            acc = node_acc[k] + longint'(weight_mem[{k[NODE_W-1:0], it.elem_index}])
                  * longint'($signed(it.value));
            node_acc[k] = sat(acc, ACC_LO, ACC_HI);
          end
          vec_fill = it.elem_index + 1;
        end
      end
      CMD_READ: begin
        if (it.node_index >= nn) begin
          r.status = ST_RANGE;
        end else if (vec_fill < ni) begin
          r.status = ST_INCOMPLETE;
        end else begin
          acc = node_acc[it.node_index] + longint'(bias_mem[it.node_index]) * 256;
          acc = sat(acc, OUT_LO, OUT_HI);
          if (relu_on && acc < 0) acc = 0;
          r.result_value = acc[RES_W-1:0];
        end
      end
    endcase
    return r;
  endfunction

  // never let a feed or read touch a weight or bias that was never loaded
  function automatic in_item_t legalise(in_item_t it);
    int ni, nn, k;
    ni = used_inputs();
    nn = used_nodes();
    if (it.command == CMD_FEED && it.elem_index < ni) begin
      for (k = 0; k < nn; k++) begin
        if (!weight_set[{k[NODE_W-1:0], it.elem_index}]) begin
          it.command = CMD_WEIGHT;
          it.node_index = k[NODE_W-1:0];
          return it;
        end
      end
    end else if (it.command == CMD_READ && it.node_index < nn && !bias_set[it.node_index]) begin
      it.command = CMD_BIAS;
    end
    return it;
  endfunction

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_gap_pct = 0;  stall_pct = 0;  end
      1: begin send_gap_pct = 76; stall_pct = 0;  end
      2: begin send_gap_pct = 0;  stall_pct = 76; end
      default: begin send_gap_pct = 9; stall_pct = 9; end
    endcase
  endtask

  task automatic send_item(cmd_t c, int node, int elem, int val);
    in_item_t it;
    out_item_t want;
    it.command = c;
    it.node_index = node[NODE_W-1:0];
    it.elem_index = elem[ELEM_W-1:0];
    it.value = val[VAL_W-1:0];
    it = legalise(it);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = layer_predict(it);
    results_due.push_back(want);
    if (want.status != ST_RANGE) items_used++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int data);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[NI_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_INPUTS: inputs_reg = data[NI_W-1:0];
      CFG_NODES:  nodes_reg = data[NN_W-1:0];
      CFG_MODE:   relu_on = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_vector(bit whole);
    int ni, nn, upto, e, k;
    ni = used_inputs();
    nn = used_nodes();
    upto = whole ? ni : $urandom_range(1, ni);
    for (e = 0; e < upto; e++) begin
      for (k = 0; k < nn; k++) begin
        if (!weight_set[{k[NODE_W-1:0], e[ELEM_W-1:0]}] || $urandom_range(3) == 0)
          send_item(CMD_WEIGHT, k, e, rand_value());
      end
      send_item(CMD_FEED, $urandom_range(63), e, rand_value());
      if ($urandom_range(7) == 0) send_item(CMD_READ, $urandom_range(nn - 1), 0, 0);
    end
    for (k = 0; k < nn; k++) begin
      if (!bias_set[k] || $urandom_range(3) == 0) send_item(CMD_BIAS, k, 0, rand_value());
    end
    repeat ($urandom_range(1, 4))
      send_item(CMD_READ, $urandom_range(0, nn < MAX_NODES ? nn : MAX_NODES - 1),
                $urandom_range(1023), rand_value());
  endtask

  task automatic test_reset_state();
    send_item(CMD_BIAS, 0, 0, 256);
    send_item(CMD_READ, 0, 0, 0);
    send_item(CMD_WEIGHT, 0, 784, 1);
    send_item(CMD_FEED, 0, 1023, 1);
  endtask

  task automatic test_commands();
    write_reg(CFG_INPUTS, 2);
    write_reg(CFG_NODES, 2);
    write_reg(CFG_MODE, 0);
    send_item(CMD_WEIGHT, 0, 0, 32767);
    send_item(CMD_WEIGHT, 0, 1, 32767);
    send_item(CMD_WEIGHT, 1, 0, -32768);
    send_item(CMD_WEIGHT, 1, 1, -32768);
    send_item(CMD_BIAS, 0, 0, -32768);
    send_item(CMD_BIAS, 1, 0, 32767);
    send_item(CMD_FEED, 0, 0, -32768);
    send_item(CMD_READ, 0, 0, 0);
    send_item(CMD_FEED, 0, 1, -32768);
    send_item(CMD_READ, 0, 0, 0);
    send_item(CMD_READ, 1, 0, 0);
    send_item(CMD_READ, 2, 0, 0);
    send_item(CMD_BIAS, 2, 0, 5);
    send_item(CMD_WEIGHT, 2, 0, 5);
    send_item(CMD_WEIGHT, 0, 2, 5);
    send_item(CMD_FEED, 0, 2, 5);
    write_reg(CFG_MODE, 1);
    send_item(CMD_READ, 0, 0, 0);
    send_item(CMD_FEED, 0, 1, 256);
    send_item(CMD_READ, 1, 0, 0);
    send_item(CMD_FEED, 0, 0, 1);
    send_item(CMD_READ, 0, 0, 0);
  endtask

  task automatic test_size_clamping();
    write_reg(CFG_INPUTS, 0);
    write_reg(CFG_NODES, 0);
    send_item(CMD_WEIGHT, 0, 0, 512);
    send_item(CMD_WEIGHT, 1, 0, 7);
    send_item(CMD_WEIGHT, 0, 1, 7);
    send_item(CMD_FEED, 0, 0, 768);
    send_item(CMD_READ, 0, 0, 0);
    send_item(CMD_READ, 1, 0, 0);
    write_reg(CFG_INPUTS, 2047);
    send_item(CMD_WEIGHT, 0, 1023, -32768);
    send_item(CMD_FEED, 0, 1023, -32768);
    send_item(CMD_READ, 0, 0, 0);
    write_reg(CFG_NODES, 127);
    send_item(CMD_READ, 63, 0, 0);
    send_item(CMD_READ, 63, 0, 0);
    write_reg(CFG_INPUTS, 1024);
    write_reg(CFG_NODES, 64);
    send_item(CMD_READ, 0, 0, 0);
  endtask

  // drive one accumulator past the 40-bit ceiling; a wrapped sum would read back negative
  task automatic test_accumulator_saturation();
    int p;
    set_idling(0);
    write_reg(CFG_INPUTS, 2);
    write_reg(CFG_NODES, 1);
    write_reg(CFG_MODE, 0);
    send_item(CMD_WEIGHT, 0, 0, 0);
    send_item(CMD_WEIGHT, 0, 1, -32768);
    send_item(CMD_BIAS, 0, 0, 0);
    send_item(CMD_FEED, 0, 0, 0);
    for (p = 0; p < 4; p++) begin
      set_idling(p);
      repeat ((p == 0) ? 129 : 128) send_item(CMD_FEED, 0, 1, -32768);
    end
    set_idling(0);
    send_item(CMD_READ, 0, 0, 0);
  endtask

  task automatic test_random();
    int start, phase, ni_v, nn_v, n;
    start = items_used;
    phase = 0;
    while (items_used - start < 100) begin
      set_idling(phase % 4);
      nn_v = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 64 : 127) : $urandom_range(0, 10);
      if (nn_v >= MAX_NODES) ni_v = $urandom_range(0, 2);
      else ni_v = ($urandom_range(5) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
      write_reg(CFG_INPUTS, ni_v);
      write_reg(CFG_NODES, nn_v);
      write_reg(CFG_MODE, $urandom_range(1));
      repeat ($urandom_range(2, 4)) begin
        n = $urandom_range(9);
        if (n < 6) begin
          run_vector(1'b1);
        end else if (n < 8) begin
          run_vector(1'b0);
        end else begin
          repeat ($urandom_range(3, 8))
            send_item(cmd_t'($urandom_range(3)), $urandom_range(63),
                      $urandom_range(1) ? $urandom_range(1023) : $urandom_range(0, used_inputs()),
                      rand_value());
        end
      end
      if ($urandom_range(3) == 0) wait_drained();
      phase++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item: value %0d status %0d", $time,
                 $signed(out_data.result_value), out_data.status);
      end else begin
        due_item = results_due.pop_front();
        if (out_data.result_value !== due_item.result_value) begin
          mismatches++;
          $display("%0t: result_value mismatch: expected %0d, got %0d", $time,
                   $signed(due_item.result_value), $signed(out_data.result_value));
        end
        if (out_data.status !== due_item.status) begin
          mismatches++;
          $display("%0t: status mismatch: expected %0d, got %0d", $time,
                   due_item.status, out_data.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("[fully_connected_layer_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_INPUTS;
    cfg_data = '0;
    send_gap_pct = 0;
    stall_pct = 0;
    mismatches = 0;
    items_used = 0;
    quiet_cycles = 0;
    vec_fill = 0;
    inputs_reg = INPUTS_RESET;
    nodes_reg = NODES_RESET;
    relu_on = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_commands();
    test_size_clamping();
    test_accumulator_saturation();
    test_random();
    wait_drained();
    repeat (80) @(posedge clk);
    if (mismatches == 0) begin
      $display("[fully_connected_layer_core] OK");
    end else begin
      $display("[fully_connected_layer_core] ERROR");
    end
    $finish;
  end

endmodule
